// ===== rtl/bpc_pkg.sv =====
// ============================================================================
// bpc_pkg: shared types and constants
// Opcodes, controller states and the command/status structs of the core.
// ============================================================================
package bpc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MC_MD   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OSS     = 3'd5;

    localparam logic ACT_TEMP  = 1'b0;
    localparam logic ACT_PRESS = 1'b1;

    // Datapath micro-operations. Each one but OP_NONE writes at least one working register.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_T_X1,      // x1 = asr((ut-ac6)*ac5, 15)
        OP_T_DEN,     // den = x1 + md, load divider
        OP_T_FIN,     // b5 = x1 + q, temp value
        OP_P_B6,      // b6 = b5 - 4000
        OP_P_SQ,      // sq = asr(b6*b6, 12)
        OP_P_X1A,     // t1 = asr(b2*sq, 11)
        OP_P_X2A,     // t2 = asr(ac2*b6, 11)
        OP_P_B3,      // b3
        OP_P_X1B,     // t1 = asr(ac3*b6, 13)
        OP_P_X2B,     // t2 = asr(b1*sq, 16)
        OP_P_X3,      // t2 = asr(t1+t2+2, 2)
        OP_P_B4,      // b4
        OP_P_B7,      // b7, load divider
        OP_P_PQ,      // p from quotient
        OP_P_S1,      // t1 = asr(p,8)^2
        OP_P_S2,      // t1 = asr(t1*3038, 16)
        OP_P_S3,      // t2 = asr(-7357*p, 16)
        OP_P_FIN      // value = p + asr(t1+t2+3791, 4)
    } bpc_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_DIVWAIT,
        ST_OUT
    } bpc_state_t;

    typedef struct packed {
        logic    load;     // latch input beat
        bpc_op_t op;
        logic    div_step;
        logic    out_load;
    } bpc_cmd_t;

    typedef struct packed {
        logic div_zero;    // divisor loaded by last op is zero
        logic div_done;
        logic kind;
    } bpc_sts_t;

    localparam int unsigned DivSteps = 32;
    localparam int unsigned DivCntW = $clog2(DivSteps + 1);

endpackage

// ===== rtl/bpc_if.sv =====
// ============================================================================
// bpc_if: valid/ready stream channel
// Generic handshake channel carrying a packed payload.
// ============================================================================
interface bpc_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/barometric_pressure_compensation_core.sv =====
// ============================================================================
// barometric_pressure_compensation_core: sensor fixed-point compensation
// Temperature and pressure compensation from raw readings and calibration.
// ============================================================================
//  channel  dir  payload
//  in       in   action[24], raw_reading[23:0]
//  out      out  kind[33], value[32:1], divide_error[0]
//  cfg      in   cfg_we, cfg_index[2:0], cfg_data[31:0]
//
// Each item runs one radix-2 division, which dominates its run time; the other
// ops use the single multiplier at most once each. A zero divisor skips the
// division. The next beat is accepted in the cycle after the result is loaded.
// Reset clears calibration to 0, oversampling to 2 and the stored b5 to 0.
// One item is in work at a time; a held result stalls only the next item.
module barometric_pressure_compensation_core (
    input  logic                          clk,
    input  logic                          rst_n,
    bpc_if.sink                           in_ch,
    bpc_if.source                         out_ch,
    input  logic                          cfg_we,
    input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data
);

    bpc_pkg::bpc_cmd_t cmd;
    bpc_pkg::bpc_sts_t sts;
    logic              res_kind;
    logic signed [31:0] res_value;
    logic              res_err;

    bpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (in_ch.data[24]),
        .in_raw    (in_ch.data[23:0]),
        .cmd       (cmd),
        .sts       (sts),
        .res_kind  (res_kind),
        .res_value (res_value),
        .res_err   (res_err)
    );

    assign out_ch.data = {res_kind, res_value, res_err};

endmodule

// ===== rtl/bpc_ctrl.sv =====
// ============================================================================
// bpc_ctrl: compensation sequencer
// Steps the datapath through the temperature or pressure op list.
// ============================================================================
module bpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bpc_pkg::bpc_sts_t   sts,
    output bpc_pkg::bpc_cmd_t   cmd
);

    bpc_pkg::bpc_state_t state_reg, state_next;
    bpc_pkg::bpc_op_t    op_reg, op_next;
    logic                out_valid_reg, out_valid_next;

    // Next op after the current one; OP_NONE ends the sequence.
    function automatic bpc_pkg::bpc_op_t succ(input bpc_pkg::bpc_op_t o);
        bpc_pkg::bpc_op_t r;
        case (o)
            bpc_pkg::OP_T_X1:  r = bpc_pkg::OP_T_DEN;
            bpc_pkg::OP_T_DEN: r = bpc_pkg::OP_T_FIN;
            bpc_pkg::OP_P_B6:  r = bpc_pkg::OP_P_SQ;
            bpc_pkg::OP_P_SQ:  r = bpc_pkg::OP_P_X1A;
            bpc_pkg::OP_P_X1A: r = bpc_pkg::OP_P_X2A;
            bpc_pkg::OP_P_X2A: r = bpc_pkg::OP_P_B3;
            bpc_pkg::OP_P_B3:  r = bpc_pkg::OP_P_X1B;
            bpc_pkg::OP_P_X1B: r = bpc_pkg::OP_P_X2B;
            bpc_pkg::OP_P_X2B: r = bpc_pkg::OP_P_X3;
            bpc_pkg::OP_P_X3:  r = bpc_pkg::OP_P_B4;
            bpc_pkg::OP_P_B4:  r = bpc_pkg::OP_P_B7;
            bpc_pkg::OP_P_B7:  r = bpc_pkg::OP_P_PQ;
            bpc_pkg::OP_P_PQ:  r = bpc_pkg::OP_P_S1;
            bpc_pkg::OP_P_S1:  r = bpc_pkg::OP_P_S2;
            bpc_pkg::OP_P_S2:  r = bpc_pkg::OP_P_S3;
            bpc_pkg::OP_P_S3:  r = bpc_pkg::OP_P_FIN;
            default:           r = bpc_pkg::OP_NONE;
        endcase
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        case (state_reg)
            bpc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bpc_pkg::ST_RUN;
                    op_next = bpc_pkg::OP_NONE;
                end
            end
            bpc_pkg::ST_RUN:
            begin
                if (op_reg == bpc_pkg::OP_NONE)
                    op_next = (sts.kind == bpc_pkg::ACT_TEMP) ? bpc_pkg::OP_T_X1
                                                              : bpc_pkg::OP_P_B6;
                else if (op_reg == bpc_pkg::OP_T_DEN || op_reg == bpc_pkg::OP_P_B7)
                    state_next = bpc_pkg::ST_DIVWAIT;
                else if (op_reg == bpc_pkg::OP_P_B4 && sts.div_zero)
                    state_next = bpc_pkg::ST_OUT;
                else if (succ(op_reg) == bpc_pkg::OP_NONE)
                    state_next = bpc_pkg::ST_OUT;
                else
                    op_next = succ(op_reg);
            end
            bpc_pkg::ST_DIVWAIT:
            begin
                // Zero divisor ends the item with an error result.
                if (sts.div_zero)
                    state_next = bpc_pkg::ST_OUT;
                else
                    state_next = bpc_pkg::ST_DIV;
            end
            bpc_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = bpc_pkg::ST_RUN;
                    op_next = succ(op_reg);
                end
            end
            bpc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = bpc_pkg::ST_IDLE;
            end
            default: state_next = bpc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            bpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bpc_pkg::ST_RUN:
            begin
                cmd.op = op_reg;
            end
            bpc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            bpc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpc_pkg::ST_IDLE;
            op_reg <= bpc_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> state_reg == bpc_pkg::ST_DIV)
        else $error("divider stepped outside division state");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == bpc_pkg::ST_RUN)
        else $error("accepted beat did not start a run");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result beat dropped while stalled");

endmodule

// ===== rtl/bpc_dp.sv =====
// ============================================================================
// bpc_dp: compensation datapath
// Calibration registers, working registers, one multiplier and a radix-2
// unsigned divider.
// ============================================================================
module bpc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          in_action,
    input  logic [23:0]                   in_raw,
    input  bpc_pkg::bpc_cmd_t             cmd,
    output bpc_pkg::bpc_sts_t             sts,
    output logic                          res_kind,
    output logic signed [31:0]            res_value,
    output logic                          res_err
);

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    logic signed [31:0] b5_reg;
    logic        kind_reg;
    logic [23:0] raw_reg;
    logic signed [31:0] x1_reg, t1_reg, t2_reg, sq_reg, b6_reg, b3_reg, b4_reg, p_reg;
    logic [31:0] val_reg;
    logic        err_reg;
    logic signed [31:0] val_next;
    logic        err_next;
    logic        zero_reg;

    // Divider: unsigned restoring, one quotient bit a cycle.
    logic [31:0] dq_reg, dd_reg, dr_reg;
    logic        dneg_reg;
    logic [bpc_pkg::DivCntW-1:0] dcnt_reg;
    logic [32:0] dtrial;
    logic [31:0] drem_sh;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [31:0] pl;

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
    logic [31:0] up, quot;

    assign ac1 = {{16{ac12_reg[31]}}, ac12_reg[31:16]};
    assign ac2 = {{16{ac12_reg[15]}}, ac12_reg[15:0]};
    assign ac3 = {{16{ac34_reg[31]}}, ac34_reg[31:16]};
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = {{16{b12_reg[31]}}, b12_reg[31:16]};
    assign b2  = {{16{b12_reg[15]}}, b12_reg[15:0]};
    assign mc  = {{16{mcmd_reg[31]}}, mcmd_reg[31:16]};
    assign md  = {{16{mcmd_reg[15]}}, mcmd_reg[15:0]};
    assign up  = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});
    assign quot = dneg_reg ? (32'd0 - dq_reg) : dq_reg;

    // Operand select for the single 32x32 multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            bpc_pkg::OP_T_X1:  begin ma = $signed({16'd0, raw_reg[15:0]}) - ac6; mb = ac5; end
            bpc_pkg::OP_P_SQ:  begin ma = b6_reg; mb = b6_reg; end
            bpc_pkg::OP_P_X1A: begin ma = b2; mb = sq_reg; end
            bpc_pkg::OP_P_X2A: begin ma = ac2; mb = b6_reg; end
            bpc_pkg::OP_P_X1B: begin ma = ac3; mb = b6_reg; end
            bpc_pkg::OP_P_X2B: begin ma = b1; mb = sq_reg; end
            bpc_pkg::OP_P_B4:  begin ma = ac4; mb = t2_reg + 32'sd32768; end
            bpc_pkg::OP_P_B7:  begin ma = $signed(up) - b3_reg;
                                     mb = $signed(32'd50000 >> oss_reg); end
            bpc_pkg::OP_P_S1:  begin ma = p_reg >>> 8; mb = p_reg >>> 8; end
            bpc_pkg::OP_P_S2:  begin ma = t1_reg; mb = 32'sd3038; end
            bpc_pkg::OP_P_S3:  begin ma = -32'sd7357; mb = p_reg; end
            default: ;
        endcase
    end
    assign prod = ma * mb;
    assign pl = prod[31:0];

    assign dtrial = {1'b0, drem_sh} - {1'b0, dd_reg};
    assign drem_sh = {dr_reg[30:0], dq_reg[31]};

    assign val_next = (kind_reg == bpc_pkg::ACT_TEMP)
                    ? ((x1_reg + $signed(quot) + 32'sd8) >>> 4)
                    : (p_reg + ((t1_reg + t2_reg + 32'sd3791) >>> 4));
    assign err_next = zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg <= '0;
            mcmd_reg <= '0;
            oss_reg <= 2'd2;
            b5_reg <= '0;
            dcnt_reg <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bpc_pkg::REG_AC1_AC2: ac12_reg <= cfg_data;
                    bpc_pkg::REG_AC3_AC4: ac34_reg <= cfg_data;
                    bpc_pkg::REG_AC5_AC6: ac56_reg <= cfg_data;
                    bpc_pkg::REG_B1_B2:   b12_reg <= cfg_data;
                    bpc_pkg::REG_MC_MD:   mcmd_reg <= cfg_data;
                    bpc_pkg::REG_OSS:     oss_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
                zero_reg <= 1'b0;
            case (cmd.op)
                bpc_pkg::OP_T_DEN:
                begin
                    zero_reg <= (x1_reg + md) == 32'sd0;
                    dcnt_reg <= bpc_pkg::DivCntW'(bpc_pkg::DivSteps);
                end
                bpc_pkg::OP_T_FIN: b5_reg <= x1_reg + quot;
                bpc_pkg::OP_P_B4:  zero_reg <= pl[31:15] == 17'd0;
                bpc_pkg::OP_P_B7:  dcnt_reg <= bpc_pkg::DivCntW'(bpc_pkg::DivSteps);
                default: ;
            endcase
            if (cmd.div_step)
                dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_action;
            raw_reg <= in_raw;
        end
        case (cmd.op)
            bpc_pkg::OP_T_X1:  x1_reg <= pl >>> 15;
            bpc_pkg::OP_T_DEN:
            begin
                // Signed division done on magnitudes.
                dd_reg <= ((x1_reg + md) < 0) ? 32'(-(x1_reg + md)) : 32'(x1_reg + md);
                dq_reg <= (mc[20] ? 32'(-(mc <<< 11)) : 32'(mc <<< 11));
                dneg_reg <= mc[20] ^ ((x1_reg + md) < 0);
                dr_reg <= '0;
            end
            bpc_pkg::OP_P_B6:  b6_reg <= b5_reg - 32'sd4000;
            bpc_pkg::OP_P_SQ:  sq_reg <= pl >>> 12;
            bpc_pkg::OP_P_X1A: t1_reg <= pl >>> 11;
            bpc_pkg::OP_P_X2A: t2_reg <= pl >>> 11;
            bpc_pkg::OP_P_B3:  b3_reg <= ((((ac1 <<< 2) + t1_reg + t2_reg) <<< oss_reg)
                                         + 32'sd2) >>> 2;
            bpc_pkg::OP_P_X1B: t1_reg <= pl >>> 13;
            bpc_pkg::OP_P_X2B: t2_reg <= pl >>> 16;
            bpc_pkg::OP_P_X3:  t2_reg <= (t1_reg + t2_reg + 32'sd2) >>> 2;
            bpc_pkg::OP_P_B4:  b4_reg <= $signed({15'd0, pl[31:15]});
            bpc_pkg::OP_P_B7:
            begin
                // Unsigned divide; b7 below 2^31 is doubled first.
                dd_reg <= b4_reg;
                dq_reg <= pl[31] ? pl : {pl[30:0], 1'b0};
                p_reg <= {31'd0, pl[31]};
                dneg_reg <= 1'b0;
                dr_reg <= '0;
            end
            bpc_pkg::OP_P_PQ:  p_reg <= p_reg[0] ? $signed({dq_reg[30:0], 1'b0})
                                                 : $signed(dq_reg);
            bpc_pkg::OP_P_S1:  t1_reg <= pl;
            bpc_pkg::OP_P_S2:  t1_reg <= pl >>> 16;
            bpc_pkg::OP_P_S3:  t2_reg <= pl >>> 16;
            default: ;
        endcase
        if (cmd.div_step)
        begin
            if (!dtrial[32])
            begin
                dr_reg <= dtrial[31:0];
                dq_reg <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                dr_reg <= drem_sh;
                dq_reg <= {dq_reg[30:0], 1'b0};
            end
        end
        if (cmd.op == bpc_pkg::OP_P_FIN || cmd.op == bpc_pkg::OP_T_FIN)
        begin
            val_reg <= zero_reg ? 32'd0 : val_next;
            err_reg <= err_next;
        end
        if (cmd.out_load)
        begin
            res_kind <= kind_reg;
            res_value <= zero_reg ? 32'sd0 : $signed(val_reg);
            res_err <= err_reg & zero_reg | zero_reg;
        end
    end

    assign sts.div_zero = zero_reg;
    assign sts.div_done = dcnt_reg == bpc_pkg::DivCntW'(1);
    assign sts.kind = kind_reg;

    a_zero_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> dd_reg != 32'd0)
        else $error("divider running on zero divisor");
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> dcnt_reg != '0)
        else $error("divider count underflow");
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.out_load) && res_err |-> res_value == 32'sd0)
        else $error("error result carries nonzero value");

endmodule

// ===== verif/tb_barometric_pressure_compensation_core.sv =====
// ============================================================================
// tb_barometric_pressure_compensation_core: compensation core testbench
// Drives tagged raw readings through several calibration sets, predicts each
// compensated result in fixed point and checks every output beat in order.
// ============================================================================
module tb_barometric_pressure_compensation_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        action;
        logic [23:0] raw;
    } reading_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        divide_error;
    } comp_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [bpc_pkg::CfgIdxW-1:0] cfg_index;
    logic [bpc_pkg::CfgDataW-1:0] cfg_data;

    bpc_if #(.W(25)) in_ch ();
    bpc_if #(.W(34)) out_ch ();

    barometric_pressure_compensation_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor copy of the calibration and the stored b5.
    logic [31:0] p_ac12, p_ac34, p_ac56, p_b12, p_mcmd;
    logic [1:0]  p_oss;
    logic signed [31:0] p_b5;

    reading_t     pending_readings[$];
    comp_result_t expected_results[$];
    int  errors;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [31:0] sx(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic comp_result_t compensate(input reading_t r);
        comp_result_t res;
        logic signed [31:0] ut, ac5, ac6, mc, md, x1, x2, x3, den, b5;
        logic signed [31:0] ac1, ac2, ac3, b1, b2, b6, sq, b3, up;
        logic [31:0] ac4, b4, b7, p;
        logic signed [63:0] q;
        res.kind = r.action;
        res.value = '0;
        res.divide_error = 1'b0;
        if (r.action == bpc_pkg::ACT_TEMP)
        begin
            ut  = {16'd0, r.raw[15:0]};
            ac5 = {16'd0, p_ac56[31:16]};
            ac6 = {16'd0, p_ac56[15:0]};
            mc  = sx(p_mcmd[31:16]);
            md  = sx(p_mcmd[15:0]);
            x1  = ((ut - ac6) * ac5) >>> 15;
            den = x1 + md;
            if (den == 0)
                res.divide_error = 1'b1;
            else
            begin
                q  = 64'(signed'(mc << 11)) / 64'(den);
                x2 = q[31:0];
                b5 = x1 + x2;
                p_b5 = b5;
                res.value = (b5 + 32'sd8) >>> 4;
            end
        end
        else
        begin
            up  = 32'(r.raw >> (8 - p_oss));
            ac1 = sx(p_ac12[31:16]);
            ac2 = sx(p_ac12[15:0]);
            ac3 = sx(p_ac34[31:16]);
            ac4 = {16'd0, p_ac34[15:0]};
            b1  = sx(p_b12[31:16]);
            b2  = sx(p_b12[15:0]);
            b6  = p_b5 - 32'sd4000;
            sq  = (b6 * b6) >>> 12;
            x1  = (b2 * sq) >>> 11;
            x2  = (ac2 * b6) >>> 11;
            x3  = x1 + x2;
            b3  = (((ac1 * 4 + x3) << p_oss) + 32'sd2) >>> 2;
            x1  = (ac3 * b6) >>> 13;
            x2  = (b1 * sq) >>> 16;
            x3  = (x1 + x2 + 32'sd2) >>> 2;
            b4  = (ac4 * (x3 + 32'd32768)) >> 15;
            if (b4 == 0)
                res.divide_error = 1'b1;
            else
            begin
                b7 = (up - b3) * (32'd50000 >> p_oss);
                if (!b7[31])
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                x1 = (signed'(p) >>> 8) * (signed'(p) >>> 8);
                x1 = (x1 * 32'sd3038) >>> 16;
                x2 = (-32'sd7357 * signed'(p)) >>> 16;
                res.value = p + 32'((x1 + x2 + 32'sd3791) >>> 4);
            end
        end
        return res;
    endfunction

    // Driver: one reading per beat after a random gap.
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            in_gap      <= 0;
        end
        else
        begin
            gap = in_gap;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(compensate(reading_t'(in_ch.data)));
                void'(pending_readings.pop_front());
                gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
            end
            if (gap > 0)
            begin
                in_gap <= gap - 1;
                in_ch.valid <= 1'b0;
            end
            else
            begin
                in_gap <= 0;
                if (pending_readings.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_readings[0];
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result beat against the oldest prediction.
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        comp_result_t got, want;
        int gap;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
        end
        else
        begin
            gap = out_gap;
            if (out_ch.valid && out_ch.ready)
            begin
                got = comp_result_t'(out_ch.data);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d got %0d", $time, want.kind,
                                 got.kind);
                        errors++;
                    end
                    if (got.value !== want.value)
                    begin
                        $display("%0t: value expected %0d got %0d", $time,
                                 signed'(want.value), signed'(got.value));
                        errors++;
                    end
                    if (got.divide_error !== want.divide_error)
                    begin
                        $display("%0t: divide_error expected %0d got %0d", $time,
                                 want.divide_error, got.divide_error);
                        errors++;
                    end
                end
                gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
            end
            if (gap > 0)
            begin
                out_gap <= gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_gap <= 0;
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [bpc_pkg::CfgIdxW-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            bpc_pkg::REG_AC1_AC2: p_ac12 = val;
            bpc_pkg::REG_AC3_AC4: p_ac34 = val;
            bpc_pkg::REG_AC5_AC6: p_ac56 = val;
            bpc_pkg::REG_B1_B2:   p_b12  = val;
            bpc_pkg::REG_MC_MD:   p_mcmd = val;
            bpc_pkg::REG_OSS:     p_oss  = val[1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_readings.size() == 0 && !in_ch.valid);
        wait (expected_results.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic push_reading(input logic act, input logic [23:0] raw);
        reading_t r;
        r.action = act;
        r.raw = raw;
        pending_readings.push_back(r);
    endtask

    // Typical datasheet calibration set.
    task automatic load_typical();
        write_reg(bpc_pkg::REG_AC1_AC2, {16'sd408, -16'sd72});
        write_reg(bpc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd32741});
        write_reg(bpc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
        write_reg(bpc_pkg::REG_B1_B2, {16'sd6190, 16'sd4});
        write_reg(bpc_pkg::REG_MC_MD, {-16'sd8711, 16'sd2868});
    endtask

    initial
    begin
        errors = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        p_ac12 = '0; p_ac34 = '0; p_ac56 = '0; p_b12 = '0; p_mcmd = '0;
        p_oss = 2'd2;
        p_b5 = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset calibration: both divisors are zero.
        push_reading(bpc_pkg::ACT_PRESS, 24'hFFFFFF);
        push_reading(bpc_pkg::ACT_TEMP, 24'h000000);
        drain();

        // Directed: typical values, field extremes, every oversampling.
        load_typical();
        push_reading(bpc_pkg::ACT_PRESS, 24'h5D23 << 8);   // pressure before temperature
        push_reading(bpc_pkg::ACT_TEMP, 24'h006C50);
        for (int o = 0; o < 4; o++)
        begin
            drain();
            write_reg(bpc_pkg::REG_OSS, 32'(o));
            push_reading(bpc_pkg::ACT_PRESS, 24'h000000);
            push_reading(bpc_pkg::ACT_PRESS, 24'hFFFFFF);
            push_reading(bpc_pkg::ACT_PRESS, 24'h5D2300);
            push_reading(bpc_pkg::ACT_TEMP, 24'hFF0000);
            push_reading(bpc_pkg::ACT_TEMP, 24'h00FFFF);
        end
        drain();
        // Temperature divisor zero: ut=ac6 gives x1=0, md=0.
        write_reg(bpc_pkg::REG_MC_MD, {16'h8000, 16'h0000});
        push_reading(bpc_pkg::ACT_TEMP, 24'h005A71);
        push_reading(bpc_pkg::ACT_PRESS, 24'h123456);
        drain();
        // Pressure divisor zero: ac4 = 0.
        write_reg(bpc_pkg::REG_AC3_AC4, {16'h7FFF, 16'h0000});
        push_reading(bpc_pkg::ACT_PRESS, 24'hABCDEF);
        drain();

        // Random phases with changing calibration sets.
        for (int ph = 0; ph < 12; ph++)
        begin
            drain();
            if (ph % 3 == 0)
                load_typical();
            else
            begin
                write_reg(bpc_pkg::REG_AC1_AC2, $urandom());
                write_reg(bpc_pkg::REG_AC3_AC4, ph == 4 ? 32'hFFFFFFFF : $urandom());
                write_reg(bpc_pkg::REG_AC5_AC6, ph == 5 ? 32'h0 : $urandom());
                write_reg(bpc_pkg::REG_B1_B2, ph == 7 ? 32'h80008000 : $urandom());
                write_reg(bpc_pkg::REG_MC_MD, ph == 8 ? 32'h7FFF7FFF : $urandom());
            end
            write_reg(bpc_pkg::REG_OSS, $urandom_range(0, 3));
            for (int i = 0; i < 75; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    push_reading(bpc_pkg::ACT_TEMP, {8'($urandom_range(0, 255)),
                                 16'h6000 + 16'($urandom_range(0, 16'h1FFF))});
                else if ($urandom_range(0, 4) == 0)
                    push_reading(1'($urandom_range(0, 1)), 24'($urandom()));
                else
                    push_reading(bpc_pkg::ACT_PRESS,
                                 24'h400000 + 24'($urandom_range(0, 24'h3FFFFF)));
            end
        end
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
